// ===== rtl/mme_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_pkg: shared types and constants of the matrix multiply engine
// Sizes, fixed-point format, item structs and command/status codes.
// ----------------------------------------------------------------------------
package mme_pkg;

  // Largest matrix dimension; the stores hold MAX_DIM x MAX_DIM entries.
  localparam int MAX_DIM   = 16;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;

  // Q4.12 elements, products summed in a wide signed accumulator.
  localparam int FRAC_BITS = 12;
  localparam int DATA_W    = 16;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W + IDX_W + 1;

  // Item fields with widths fixed by the interface.
  localparam int CMD_W     = 2;
  localparam int ROW_W     = 4;
  localparam int COL_W     = 4;
  localparam int STATUS_W  = 2;
  localparam int SIZE_W    = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_SECOND = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [ROW_W-1:0]         row_index;
    logic [COL_W-1:0]         col_index;
    logic signed [DATA_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] product_value;
    logic [STATUS_W-1:0]      status;
  } out_item_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;       // start of a dot product
    logic data_valid;  // store read data valid this cycle
  } mac_ctrl_t;

endpackage

// ===== rtl/mme_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/mme_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_mac: multiply-accumulate and rescale unit
// Registered 16x16 multiply, wide accumulator, round and saturate to Q4.12.
// ----------------------------------------------------------------------------
module mme_mac (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mme_pkg::mac_ctrl_t               ctrl,
  input  logic signed [mme_pkg::DATA_W-1:0] a_data,
  input  logic signed [mme_pkg::DATA_W-1:0] b_data,
  output logic                             busy,
  output logic signed [mme_pkg::DATA_W-1:0] result,
  output logic                             saturated
);
  import mme_pkg::*;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS =
    (FRAC_BITS > 0) ? ACC_W'(1) <<< (FRAC_BITS - 1) : '0;
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((1 << (DATA_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -(ACC_W'(1) <<< (DATA_W - 1));

  logic                     prod_v_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  rounded;
  logic signed [ACC_W-1:0]  scaled;
  logic                     sat_hi;
  logic                     sat_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctrl.data_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a_data * b_data;
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // Round to nearest, ties up, then floor shift.
  always_comb begin
    rounded   = acc_r + ROUND_BIAS;
    scaled    = rounded >>> FRAC_BITS;
    sat_hi    = scaled > SAT_MAX;
    sat_lo    = scaled < SAT_MIN;
    saturated = sat_hi || sat_lo;
    if (sat_hi) begin
      result = SAT_MAX[DATA_W-1:0];
    end else if (sat_lo) begin
      result = SAT_MIN[DATA_W-1:0];
    end else begin
      result = scaled[DATA_W-1:0];
    end
  end

  assign busy = prod_v_r;

endmodule

// ===== rtl/matrix_multiply_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_engine_unit: dense matrix product engine, Q4.12
// Stores A and B in two RAMs and returns one element of C = A x B per
// compute command, rounded and saturated to Q4.12.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                            | Carries
//  --------+----------------------------------+------------------------------
//  input   | in_valid / in_ready / in_item    | cmd, row, col, element value
//  result  | out_valid / out_ready / out_item | product value, status
//  config  | cfg_valid / cfg_ready / cfg_*    | size register index and data
//
//  Load and rejected items: the store write and the result land in the
//  same edge. A compute item passes through the accept cycle, one read of
//  each RAM per inner element (inner_size capped at 16), then the RAM,
//  multiply and accumulate registers and the rescale into the output
//  register; with an inner size of 0 it skips the reads. The single read
//  port of each RAM sets the pace. Reset (rst_n low, synchronous) clears
//  control and sets all sizes to 16; the stores are not cleared. A stalled
//  result holds in the output register; a new item is taken while it waits
//  only if out_ready frees the register in the same cycle.
//
module matrix_multiply_engine_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mme_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mme_pkg::out_item_t                out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mme_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mme_pkg::SIZE_W-1:0]        cfg_data
);
  import mme_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } state_t;

  // Cap a size register at the store dimension.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    if (v > SIZE_W'(MAX_DIM)) begin
      return SIZE_W'(MAX_DIM);
    end
    return v;
  endfunction

  state_t              state_r, state_nxt;
  logic [SIZE_W-1:0]   rows_first_r, inner_size_r, cols_second_r;
  logic [IDX_W-1:0]    row_r, row_nxt;
  logic [IDX_W-1:0]    col_r, col_nxt;
  logic [SIZE_W-1:0]   k_r, k_nxt;
  logic [SIZE_W-1:0]   n_k_r, n_k_nxt;
  logic                rd_v_r, rd_v_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  logic [SIZE_W-1:0]   n_rows, n_inner, n_cols;
  logic [SIZE_W-1:0]   in_row, in_col;
  logic                in_fire;
  logic                out_free;
  logic                row_ok_a, col_ok_a, row_ok_b, col_ok_b;
  logic                a_we, b_we;
  logic                issue;
  logic [ADDR_W-1:0]   a_raddr, b_raddr, waddr;
  logic [DATA_W-1:0]   a_rdata, b_rdata;
  mac_ctrl_t           mac_ctrl;
  logic                mac_busy;
  logic signed [DATA_W-1:0] mac_result;
  logic                mac_sat;

  // --------------------------------------------------------------------------
  // Size registers: always ready, index beyond the list is dropped.
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_first_r  <= SIZE_RESET;
      inner_size_r  <= SIZE_RESET;
      cols_second_r <= SIZE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_ROWS_FIRST) begin
        rows_first_r <= cfg_data;
      end
      if (cfg_index == REG_INNER_SIZE) begin
        inner_size_r <= cfg_data;
      end
      if (cfg_index == REG_COLS_SECOND) begin
        cols_second_r <= cfg_data;
      end
    end
  end

  assign n_rows  = eff_size(rows_first_r);
  assign n_inner = eff_size(inner_size_r);
  assign n_cols  = eff_size(cols_second_r);

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;

  assign in_row   = SIZE_W'(in_item.row_index);
  assign in_col   = SIZE_W'(in_item.col_index);
  assign row_ok_a = in_row < n_rows;
  assign col_ok_a = in_col < n_inner;
  assign row_ok_b = in_row < n_inner;
  assign col_ok_b = in_col < n_cols;

  // Loads write the store in the accept cycle.
  assign a_we  = in_fire && (in_item.cmd == CMD_LOAD_A) && row_ok_a && col_ok_a;
  assign b_we  = in_fire && (in_item.cmd == CMD_LOAD_B) && row_ok_b && col_ok_b;
  assign waddr = {in_item.row_index[IDX_W-1:0], in_item.col_index[IDX_W-1:0]};

  // A[row][k] and B[k][col] for the current inner step.
  assign issue   = (state_r == S_RUN);
  assign a_raddr = {row_r, k_r[IDX_W-1:0]};
  assign b_raddr = {k_r[IDX_W-1:0], col_r};

  mme_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_first_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (in_item.element_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mme_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_second_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (in_item.element_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  assign mac_ctrl.clear      = in_fire && (in_item.cmd == CMD_COMPUTE);
  assign mac_ctrl.data_valid = rd_v_r;

  mme_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (mac_ctrl),
    .a_data    (a_rdata),
    .b_data    (b_rdata),
    .busy      (mac_busy),
    .result    (mac_result),
    .saturated (mac_sat)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    k_nxt         = k_r;
    n_k_nxt       = n_k_r;
    rd_v_nxt      = issue;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_item_nxt.product_value = '0;
          out_item_nxt.status        = ST_RANGE;
          priority case (in_item.cmd)
            CMD_LOAD_A: begin
              out_valid_nxt = 1'b1;
              if (row_ok_a && col_ok_a) begin
                out_item_nxt.status = ST_OK;
              end
            end
            CMD_LOAD_B: begin
              out_valid_nxt = 1'b1;
              if (row_ok_b && col_ok_b) begin
                out_item_nxt.status = ST_OK;
              end
            end
            CMD_COMPUTE: begin
              if (row_ok_a && col_ok_b) begin
                // Latch the coordinates and inner count, start the walk.
                row_nxt   = in_item.row_index[IDX_W-1:0];
                col_nxt   = in_item.col_index[IDX_W-1:0];
                k_nxt     = '0;
                n_k_nxt   = n_inner;
                state_nxt = (n_inner == '0) ? S_DRAIN : S_RUN;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_RUN: begin
        if (k_r == n_k_r - SIZE_W'(1)) begin
          state_nxt = S_DRAIN;
        end else begin
          k_nxt = k_r + SIZE_W'(1);
        end
      end
      S_DRAIN: begin
        // Wait for the last product to reach the accumulator.
        if (!rd_v_r && !mac_busy) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_item_nxt.product_value = mac_result;
          out_item_nxt.status        = mac_sat ? ST_SAT : ST_OK;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      n_k_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      n_k_r       <= n_k_nxt;
    end
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> k_r < n_k_r)
    else $error("inner index past latched inner size");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_RANGE |-> out_item.product_value == '0)
    else $error("rejected item carries a nonzero product");

  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_SAT |->
      out_item.product_value == 16'sh7FFF || out_item.product_value == 16'sh8000)
    else $error("saturated result is not a bound");

  a_compute_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_item.cmd == CMD_COMPUTE && row_ok_a && col_ok_b |=> !in_ready)
    else $error("input taken while a product is in progress");

endmodule

// ===== tb/mme_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_scoreboard_pkg: product predictor and result scoreboard
// Keeps a private copy of both matrices and the size registers, works out
// the expected product element or status for every accepted item and
// compares results against them in order.
// ----------------------------------------------------------------------------
package mme_scoreboard_pkg;
  import mme_pkg::*;

  typedef struct {
    in_item_t  cause;
    out_item_t result;
  } awaited_result_t;

  class product_scoreboard;
    logic signed [DATA_W-1:0] first_copy  [DEPTH];
    logic signed [DATA_W-1:0] second_copy [DEPTH];
    bit                       first_set   [DEPTH];
    bit                       second_set  [DEPTH];
    logic [SIZE_W-1:0]        size_reg    [3];
    awaited_result_t          expected_results [$];
    int mismatches;
    int products;
    int saturated;
    int rejected;

    function new();
      foreach (first_copy[i]) begin
        first_copy[i]  = '0;
        second_copy[i] = '0;
        first_set[i]   = 1'b0;
        second_set[i]  = 1'b0;
      end
      foreach (size_reg[i]) size_reg[i] = SIZE_RESET;
      mismatches = 0;
      products   = 0;
      saturated  = 0;
      rejected   = 0;
    endfunction

    // Size in use on one dimension: register value capped at MAX_DIM.
    function int eff(input logic [CFG_IDX_W-1:0] idx);
      return (size_reg[idx] > MAX_DIM) ? MAX_DIM : int'(size_reg[idx]);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_config(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
      // Indexes past the last register are dropped by the block.
      if (idx <= REG_COLS_SECOND) size_reg[idx] = data;
    endfunction

    // Apply one accepted item to the matrix copies and queue its result.
    function void accept_item(input in_item_t it);
      int              nr;
      int              nk;
      int              nc;
      int              r;
      int              c;
      longint          acc;
      longint          scaled;
      awaited_result_t ent;
      nr = eff(REG_ROWS_FIRST);
      nk = eff(REG_INNER_SIZE);
      nc = eff(REG_COLS_SECOND);
      r  = int'(it.row_index);
      c  = int'(it.col_index);
      ent.cause = it;
      ent.result.product_value = '0;
      ent.result.status        = ST_OK;
      case (it.cmd)
        CMD_LOAD_A: begin
          if (r < nr && c < nk) begin
            first_copy[r*MAX_DIM+c] = it.element_value;
            first_set[r*MAX_DIM+c]  = 1'b1;
          end else begin
            ent.result.status = ST_RANGE;
          end
        end
        CMD_LOAD_B: begin
          if (r < nk && c < nc) begin
            second_copy[r*MAX_DIM+c] = it.element_value;
            second_set[r*MAX_DIM+c]  = 1'b1;
          end else begin
            ent.result.status = ST_RANGE;
          end
        end
        CMD_COMPUTE: begin
          if (r < nr && c < nc) begin
            products++;
            acc = 0;
            for (int k = 0; k < nk; k++) begin
              acc += longint'(first_copy[r*MAX_DIM+k]) * longint'(second_copy[k*MAX_DIM+c]);
            end
            // Round half up, then floor shift back to Q4.12.
            if (FRAC_BITS > 0) acc += longint'(1) << (FRAC_BITS - 1);
            scaled = acc >>> FRAC_BITS;
            if (scaled > 32767) begin
              ent.result.product_value = 16'sh7FFF;
              ent.result.status        = ST_SAT;
              saturated++;
            end else if (scaled < -32768) begin
              ent.result.product_value = 16'sh8000;
              ent.result.status        = ST_SAT;
              saturated++;
            end else begin
              ent.result.product_value = DATA_W'(scaled);
            end
          end else begin
            ent.result.status = ST_RANGE;
          end
        end
        default: ent.result.status = ST_RANGE;
      endcase
      if (ent.result.status == ST_RANGE) rejected++;
      expected_results.push_back(ent);
    endfunction

    function void report(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch %0d: %s", mismatches, msg);
    endfunction

    function void check_result(input out_item_t got);
      awaited_result_t ent;
      if (expected_results.size() == 0) begin
        report($sformatf("result with none awaited: value %0d status %0d",
                         got.product_value, got.status));
        return;
      end
      ent = expected_results.pop_front();
      if (got.product_value !== ent.result.product_value ||
          got.status !== ent.result.status) begin
        report($sformatf("cmd %0d row %0d col %0d: expected value %0d status %0d, got value %0d status %0d",
                         ent.cause.cmd, ent.cause.row_index, ent.cause.col_index,
                         ent.result.product_value, ent.result.status,
                         got.product_value, got.status));
      end
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench of the matrix multiply engine
// Loads elements of both matrices, asks for product elements under a series
// of size settings and checks every result against a predictor, with bursty
// input traffic and a stalling result receiver.
// ----------------------------------------------------------------------------
module tb;
  import mme_pkg::*;
  import mme_scoreboard_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_ITEMS   = 950;
  localparam int PHASES         = 10;
  // Leave ample room before a size write.
  localparam int SETTLE_CYCLES  = 2 * MAX_DIM + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  // Command code with no meaning; the block rejects it.
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0]    cfg_data  = '0;

  product_scoreboard sb = new();

  int items_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  int settings    = 0;
  int rx_mode     = 0;
  int rx_mode_left = 0;
  int rx_phase    = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  matrix_multiply_engine_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Monitor: check the result transfer before noting the input transfer of
  // the same edge, so a stray result can never pop an expectation queued now.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_item);
      if (in_valid && in_ready) sb.accept_item(in_item);
    end
  end

  // Watchdog: count edges with no transfer on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, sb.pending());
      $display("tb: FAIL");
      $finish;
    end
  end

  // Receiver: pick a new stall pattern whenever the current one runs out:
  // always ready, mostly ready, a fixed duty cycle, mostly stalled.
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(50, 200);
      rx_phase     = 0;
    end else begin
      rx_mode_left--;
    end
    rx_phase++;
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 9) < 7);
      2:       out_ready <= ((rx_phase % 7) < 4);
      default: out_ready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  function automatic in_item_t make_item(input logic [CMD_W-1:0] cmd, input int r, input int c,
                                         input logic [DATA_W-1:0] v);
    in_item_t it;
    it.cmd           = cmd;
    it.row_index     = ROW_W'(r);
    it.col_index     = COL_W'(c);
    it.element_value = v;
    return it;
  endfunction

  // Element values: mostly within +/-1.0 so sums stay in range, some full
  // range and some corner codes to drive saturation.
  function automatic logic [DATA_W-1:0] rand_elem();
    logic [DATA_W-1:0] corner [7];
    corner = '{16'h7FFF, 16'h8000, 16'h0000, 16'h1000, 16'hF000, 16'h0001, 16'hFFFF};
    case ($urandom_range(0, 3))
      0, 1:    return DATA_W'(int'($urandom_range(0, 8191)) - 4096);
      2:       return DATA_W'($urandom);
      default: return corner[$urandom_range(0, 6)];
    endcase
  endfunction

  // Drive one input transfer. Enter and leave at a falling edge. Between
  // bursts drop valid for a random gap; within a burst hold valid high.
  task automatic push_item(input in_item_t it);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has come back, then
  // let the block settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One register transfer; valid is lowered at the falling edge after the transfer so
  // back-to-back writes never assign it twice in one step.
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_sizes(input int rows, input int inner, input int cols);
    wait_idle();
    write_cfg(REG_ROWS_FIRST, SIZE_W'(rows));
    write_cfg(REG_INNER_SIZE, SIZE_W'(inner));
    write_cfg(REG_COLS_SECOND, SIZE_W'(cols));
    // The unused index must leave every size alone.
    write_cfg(CFG_IDX_W'(3), SIZE_W'($urandom));
    settings++;
  endtask

  // Ask for one product element; first load any element of the row of A or
  // column of B that has never been written, so no store read sees junk.
  task automatic run_compute(input int r, input int c);
    int nk;
    nk = sb.eff(REG_INNER_SIZE);
    for (int k = 0; k < nk; k++) begin
      if (!sb.first_set[r*MAX_DIM+k]) push_item(make_item(CMD_LOAD_A, r, k, rand_elem()));
      if (!sb.second_set[k*MAX_DIM+c]) push_item(make_item(CMD_LOAD_B, k, c, rand_elem()));
    end
    push_item(make_item(CMD_COMPUTE, r, c, DATA_W'($urandom)));
  endtask

  task automatic random_step();
    int               nr;
    int               nk;
    int               nc;
    int               pick;
    int               r;
    int               c;
    int               rl;
    int               cl;
    logic [31:0]      raw;
    logic [CMD_W-1:0] cmd;
    in_item_t         it;
    nr   = sb.eff(REG_ROWS_FIRST);
    nk   = sb.eff(REG_INNER_SIZE);
    nc   = sb.eff(REG_COLS_SECOND);
    pick = $urandom_range(0, 99);
    if (pick < 40 && nr > 0 && nc > 0) begin
      run_compute($urandom_range(0, nr - 1), $urandom_range(0, nc - 1));
    end else if (pick < 58 && nr > 0 && nk > 0) begin
      push_item(make_item(CMD_LOAD_A, $urandom_range(0, nr - 1), $urandom_range(0, nk - 1),
                          rand_elem()));
    end else if (pick < 76 && nk > 0 && nc > 0) begin
      push_item(make_item(CMD_LOAD_B, $urandom_range(0, nk - 1), $urandom_range(0, nc - 1),
                          rand_elem()));
    end else if (pick < 90) begin
      // Noise: any bit pattern; an in-range compute still gets its operands.
      raw = $urandom;
      it  = raw[$bits(in_item_t)-1:0];
      if (it.cmd == CMD_COMPUTE && int'(it.row_index) < nr && int'(it.col_index) < nc) begin
        run_compute(int'(it.row_index), int'(it.col_index));
      end else begin
        push_item(it);
      end
    end else begin
      // Deliberately outside the sizes in use; fall back to the bad command
      // when every index is legal.
      cmd = CMD_W'($urandom_range(0, 2));
      rl  = (cmd == CMD_LOAD_B) ? nk : nr;
      cl  = (cmd == CMD_LOAD_A) ? nk : nc;
      r   = (rl < MAX_DIM) ? $urandom_range(rl, MAX_DIM - 1) : $urandom_range(0, MAX_DIM - 1);
      c   = (cl < MAX_DIM) ? $urandom_range(cl, MAX_DIM - 1) : $urandom_range(0, MAX_DIM - 1);
      if (r < rl && c < cl) cmd = CMD_NONE;
      push_item(make_item(cmd, r, c, rand_elem()));
    end
  endtask

  // Size settings of the random phases; -1 picks any 5-bit value.
  int phase_sizes [PHASES][3] = '{
    '{3, 4, 5}, '{16, 16, 16}, '{1, 1, 1}, '{31, 0, 20}, '{0, 7, 9},
    '{16, 2, 16}, '{8, 16, 4}, '{17, 31, 16}, '{-1, -1, -1}, '{-1, -1, -1}
  };

  initial begin
    int dims [3];
    int goal;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: 2x2 matrices with the extremes of the Q4.12 range.
    set_sizes(2, 2, 2);
    push_item(make_item(CMD_LOAD_A, 0, 0, 16'h7FFF));
    push_item(make_item(CMD_LOAD_A, 0, 1, 16'h7FFF));
    push_item(make_item(CMD_LOAD_B, 0, 0, 16'h7FFF));
    push_item(make_item(CMD_LOAD_B, 1, 0, 16'h7FFF));
    push_item(make_item(CMD_COMPUTE, 0, 0, 16'h0000));   // saturate high
    push_item(make_item(CMD_LOAD_B, 0, 1, 16'h8000));
    push_item(make_item(CMD_LOAD_B, 1, 1, 16'h8000));
    push_item(make_item(CMD_COMPUTE, 0, 1, 16'hFFFF));   // saturate low
    push_item(make_item(CMD_LOAD_A, 1, 0, 16'h1000));
    push_item(make_item(CMD_LOAD_A, 1, 1, 16'h0000));
    push_item(make_item(CMD_COMPUTE, 1, 0, 16'h0000));   // exactly the top code
    push_item(make_item(CMD_COMPUTE, 1, 1, 16'h0000));   // exactly the bottom code
    // Half an LSB either side: a tie rounds toward plus infinity.
    push_item(make_item(CMD_LOAD_B, 0, 0, 16'h0800));
    push_item(make_item(CMD_LOAD_A, 1, 0, 16'h0001));
    push_item(make_item(CMD_COMPUTE, 1, 0, 16'h0000));
    push_item(make_item(CMD_LOAD_B, 0, 1, 16'hF800));
    push_item(make_item(CMD_COMPUTE, 1, 1, 16'h0000));
    // Indexes outside the sizes in use, and the bad command.
    push_item(make_item(CMD_LOAD_A, 2, 0, 16'h1234));
    push_item(make_item(CMD_LOAD_B, 0, 2, 16'h4321));
    push_item(make_item(CMD_LOAD_A, 0, 15, 16'h8000));
    push_item(make_item(CMD_COMPUTE, 2, 0, 16'h0000));
    push_item(make_item(CMD_COMPUTE, 0, 15, 16'h0000));
    push_item(make_item(CMD_NONE, 15, 15, 16'hFFFF));

    // Random phases, each under its own sizes.
    goal = items_sent;
    for (int p = 0; p < PHASES; p++) begin
      for (int d = 0; d < 3; d++) begin
        dims[d] = (phase_sizes[p][d] < 0) ? $urandom_range(0, 31) : phase_sizes[p][d];
      end
      set_sizes(dims[0], dims[1], dims[2]);
      goal += RANDOM_ITEMS / PHASES;
      while (items_sent < goal) random_step();
    end

    wait_idle();
    $display("tb: %0d items over %0d size settings: %0d products (%0d saturated), %0d rejected",
             items_sent, settings, sb.products, sb.saturated, sb.rejected);
    $display("tb: %0d mismatches, %0d results never returned", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mme_pkg.sv
rtl/mme_ram.sv
rtl/mme_mac.sv
rtl/matrix_multiply_engine_unit.sv
tb/mme_scoreboard_pkg.sv
tb/tb.sv
